### design/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types, codes and sizes for the multi-timer table: entry layout,
// operation and result codes, and the control bundle for the head cell.
// ----------------------------------------------------------------------------
`default_nettype none

package mtt_pkg;

  // table geometry
  localparam int NUM_TIMERS  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CW          = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int IW          = (CW > 4) ? CW : 4;
  localparam int RW          = $clog2(MAX_RESULTS + 1);

  // operation codes
  localparam logic [2:0] OP_ALLOC       = 3'd0;
  localparam logic [2:0] OP_FREE        = 3'd1;
  localparam logic [2:0] OP_SET_DATA    = 3'd2;
  localparam logic [2:0] OP_SET_TIMEOUT = 3'd3;
  localparam logic [2:0] OP_TICK        = 3'd4;

  // result kinds
  localparam logic [2:0] K_DONE    = 3'd0;
  localparam logic [2:0] K_ALLOC   = 3'd1;
  localparam logic [2:0] K_FAIL    = 3'd2;
  localparam logic [2:0] K_EXPIRED = 3'd3;
  localparam logic [2:0] K_NOEXP   = 3'd4;

  // entry status codes
  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] timeout;
    logic [7:0]  data;
  } entry_t;

  // control into the head cell
  typedef struct packed {
    logic [2:0]  op;
    logic        hit;
    logic        found;
    logic [31:0] timeout;
    logic [7:0]  data;
  } proc_ctl_t;

  // events out of the head cell
  typedef struct packed {
    logic claim;
    logic expire;
  } proc_evt_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

### design/mtt_cell.sv
// ----------------------------------------------------------------------------
// mtt_cell
// One storage stage of the timer ring: holds one entry and loads its input
// entry (its neighbor's, or the updated head entry at the tail) on every shift cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire mtt_pkg::entry_t d,
  output mtt_pkg::entry_t      q
);

  // entry register, cleared to a free entry at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

### design/mtt_proc.sv
// ----------------------------------------------------------------------------
// mtt_proc
// Head-of-ring update: applies the current operation to the entry that sits
// at the head of the ring and reports claim and expiry events.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_proc (
  input  wire mtt_pkg::entry_t    head,
  input  wire mtt_pkg::proc_ctl_t ctl,
  output mtt_pkg::entry_t         upd,
  output mtt_pkg::proc_evt_t      evt
);

  logic [31:0] dec;

  assign dec = head.timeout - 32'd1;

  // per-operation entry update
  always_comb begin
    upd        = head;
    evt.claim  = 1'b0;
    evt.expire = 1'b0;
    case (ctl.op)
      mtt_pkg::OP_ALLOC: begin
        if (!ctl.found && head.status == mtt_pkg::ST_FREE) begin
          upd.status = mtt_pkg::ST_ALLOC;
          evt.claim  = 1'b1;
        end
      end
      mtt_pkg::OP_FREE: begin
        if (ctl.hit) begin
          upd.status = mtt_pkg::ST_FREE;
        end
      end
      mtt_pkg::OP_SET_DATA: begin
        if (ctl.hit) begin
          upd.data = ctl.data;
        end
      end
      mtt_pkg::OP_SET_TIMEOUT: begin
        if (ctl.hit) begin
          upd.timeout = ctl.timeout;
          upd.status  = mtt_pkg::ST_RUN;
        end
      end
      mtt_pkg::OP_TICK: begin
        if (head.status == mtt_pkg::ST_RUN) begin
          upd.timeout = dec;
          if (dec == 32'd0) begin
            upd.status = mtt_pkg::ST_ALLOC;
            evt.expire = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### design/multi_timer_table_core.sv
// Sequence: an accepted item walks the ring in S_WALK, bringing each entry to the
// head cell in index order, then S_FINISH loads the final result into the output
// register; output stalls during a tick walk or in S_FINISH pause the item.
// Throughput: no new item is taken until the core is back in S_IDLE, since the
// ring rotation brings every entry past the single head update cell.
// Reset: synchronous; all entries free with zero timeout and data, tick count zero.
// ----------------------------------------------------------------------------
// multi_timer_table_core
// Table of software timers kept in a ring of cells. Each transaction rotates
// the ring once, so every entry passes the head update cell in index order.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_timer_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [3:0]  timer_index,
  input  wire logic [31:0] timeout_ticks,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       result_kind,
  output logic [3:0]       entry_index,
  output logic [7:0]       expired_data,
  output logic [31:0]      ticks_seen,
  output logic             last
);

  mtt_pkg::state_t state, state_next;
  logic [mtt_pkg::CW-1:0] cnt, cnt_next;
  logic                   found, found_next;
  logic                   pend_valid, pend_valid_next;
  logic [mtt_pkg::RW-1:0] nres, nres_next;
  logic                   out_valid_next;
  logic [31:0]            tick_total, tick_total_next;

  logic [2:0]  op_reg, op_reg_next;
  logic [3:0]  idx_reg, idx_reg_next;
  logic [31:0] tmo_reg, tmo_reg_next;
  logic [7:0]  dat_reg, dat_reg_next;
  logic [3:0]  alloc_idx, alloc_idx_next;
  logic [3:0]  pend_idx, pend_idx_next;
  logic [7:0]  pend_data, pend_data_next;
  logic [2:0]  result_kind_next;
  logic [3:0]  entry_index_next;
  logic [7:0]  expired_data_next;
  logic [31:0] ticks_seen_next;
  logic        last_next;

  mtt_pkg::entry_t    chain [mtt_pkg::NUM_TIMERS];
  mtt_pkg::entry_t    upd;
  mtt_pkg::proc_ctl_t ctl;
  mtt_pkg::proc_evt_t evt;
  logic               shift;
  logic               out_free;
  logic               capture;
  logic               push;

  // ring of entry cells, head at position zero, updated entry enters the tail
  for (genvar k = 0; k < mtt_pkg::NUM_TIMERS; k++) begin : g_cell
    mtt_pkg::entry_t d;
    if (k == mtt_pkg::NUM_TIMERS - 1) begin : g_tail
      assign d = upd;
    end else begin : g_mid
      assign d = chain[k+1];
    end
    mtt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .q     (chain[k])
    );
  end

  // head update
  always_comb begin
    ctl.op      = op_reg;
    ctl.hit     = (mtt_pkg::IW'(cnt) == mtt_pkg::IW'(idx_reg));
    ctl.found   = found;
    ctl.timeout = tmo_reg;
    ctl.data    = dat_reg;
  end

  mtt_proc u_proc (
    .head (chain[0]),
    .ctl  (ctl),
    .upd  (upd),
    .evt  (evt)
  );

  assign in_stall = (state != mtt_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign capture  = evt.expire && (nres < mtt_pkg::RW'(mtt_pkg::MAX_RESULTS));
  assign push     = capture && pend_valid;

  // next state and result register loading
  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    found_next        = found;
    pend_valid_next   = pend_valid;
    nres_next         = nres;
    out_valid_next    = out_valid && out_stall;
    tick_total_next   = tick_total;
    op_reg_next       = op_reg;
    idx_reg_next      = idx_reg;
    tmo_reg_next      = tmo_reg;
    dat_reg_next      = dat_reg;
    alloc_idx_next    = alloc_idx;
    pend_idx_next     = pend_idx;
    pend_data_next    = pend_data;
    result_kind_next  = result_kind;
    entry_index_next  = entry_index;
    expired_data_next = expired_data;
    ticks_seen_next   = ticks_seen;
    last_next         = last;
    shift             = 1'b0;
    case (state)
      mtt_pkg::S_IDLE: begin
        if (in_valid) begin
          op_reg_next     = operation;
          idx_reg_next    = timer_index;
          tmo_reg_next    = timeout_ticks;
          dat_reg_next    = data_byte;
          cnt_next        = '0;
          found_next      = 1'b0;
          pend_valid_next = 1'b0;
          nres_next       = '0;
          if (operation == mtt_pkg::OP_TICK) begin
            tick_total_next = tick_total + 32'd1;
          end
          state_next = mtt_pkg::S_WALK;
        end
      end
      mtt_pkg::S_WALK: begin
        if (!push || out_free) begin
          shift = 1'b1;
          if (evt.claim) begin
            found_next     = 1'b1;
            alloc_idx_next = 4'(cnt);
          end
          // hold the newest expiry back so the final one can carry last
          if (capture) begin
            pend_valid_next = 1'b1;
            pend_idx_next   = 4'(cnt);
            pend_data_next  = chain[0].data;
            nres_next       = nres + mtt_pkg::RW'(1);
          end
          if (push) begin
            out_valid_next    = 1'b1;
            result_kind_next  = mtt_pkg::K_EXPIRED;
            entry_index_next  = pend_idx;
            expired_data_next = pend_data;
            ticks_seen_next   = tick_total;
            last_next         = 1'b0;
          end
          if (cnt == mtt_pkg::CW'(mtt_pkg::NUM_TIMERS - 1)) begin
            cnt_next   = '0;
            state_next = mtt_pkg::S_FINISH;
          end else begin
            cnt_next = cnt + mtt_pkg::CW'(1);
          end
        end
      end
      mtt_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          ticks_seen_next   = tick_total;
          last_next         = 1'b1;
          entry_index_next  = 4'd0;
          expired_data_next = 8'd0;
          if (op_reg == mtt_pkg::OP_ALLOC) begin
            if (found) begin
              result_kind_next = mtt_pkg::K_ALLOC;
              entry_index_next = alloc_idx;
            end else begin
              result_kind_next = mtt_pkg::K_FAIL;
            end
          end else if (op_reg == mtt_pkg::OP_TICK) begin
            if (pend_valid) begin
              result_kind_next  = mtt_pkg::K_EXPIRED;
              entry_index_next  = pend_idx;
              expired_data_next = pend_data;
            end else begin
              result_kind_next = mtt_pkg::K_NOEXP;
            end
          end else begin
            result_kind_next = mtt_pkg::K_DONE;
          end
          pend_valid_next = 1'b0;
          state_next      = mtt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mtt_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mtt_pkg::S_IDLE;
      cnt        <= '0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      nres       <= '0;
      out_valid  <= 1'b0;
      tick_total <= 32'd0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      found      <= found_next;
      pend_valid <= pend_valid_next;
      nres       <= nres_next;
      out_valid  <= out_valid_next;
      tick_total <= tick_total_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_reg       <= op_reg_next;
    idx_reg      <= idx_reg_next;
    tmo_reg      <= tmo_reg_next;
    dat_reg      <= dat_reg_next;
    alloc_idx    <= alloc_idx_next;
    pend_idx     <= pend_idx_next;
    pend_data    <= pend_data_next;
    result_kind  <= result_kind_next;
    entry_index  <= entry_index_next;
    expired_data <= expired_data_next;
    ticks_seen   <= ticks_seen_next;
    last         <= last_next;
  end

`ifndef NO_ASSERTIONS
  // an accepted transaction starts a walk at the head entry
  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == mtt_pkg::S_WALK && cnt == '0))
    else $error("walk did not start after accept");

  // reported expiries never exceed the per-tick limit
  a_nres_cap: assert property (@(posedge clk) disable iff (rst)
    nres <= mtt_pkg::RW'(mtt_pkg::MAX_RESULTS))
    else $error("expiry count above limit");

  // a held expiry only exists for a tick
  a_pend_tick: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (op_reg == mtt_pkg::OP_TICK))
    else $error("held expiry outside a tick");

  // a result pushed mid-walk is never marked final
  a_mid_not_last: assert property (@(posedge clk) disable iff (rst)
    (state == mtt_pkg::S_WALK && push && out_free) |=> (out_valid && !last))
    else $error("mid-walk result marked last");
`endif

endmodule

`default_nettype wire

### tb/sv/multi_timer_table_core_tb.sv
// ----------------------------------------------------------------------------
// multi_timer_table_core_tb
// Self-checking bench for the timer table. A queued driver feeds allocate,
// free, set data, set timeout, tick and reserved opcodes into the core. A
// shadow table predicts every result, and the monitor checks each output
// transaction field by field. Both ports idle at random and a long output
// hold forces the core to back up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multi_timer_table_core_tb;
  import mtt_pkg::*;

  // reserved opcodes, expected to leave the table untouched
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  localparam int RANDOM_ITEMS   = 45;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES    = 4 * (NUM_TIMERS + 2);

  typedef enum logic [1:0] {
    PACE_RX_SLOW,
    PACE_TX_SLOW,
    PACE_FULL
  } pace_t;

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  index;
    logic [31:0] timeout;
    logic [7:0]  data;
    pace_t       pace;
    bit          hold_rx;
    bit          drain_first;
  } timer_cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  index;
    logic [7:0]  data;
    logic [31:0] ticks;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = '0;
  logic [3:0]  timer_index = '0;
  logic [31:0] timeout_ticks = '0;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  result_kind;
  logic [3:0]  entry_index;
  logic [7:0]  expired_data;
  logic [31:0] ticks_seen;
  logic        last;

  multi_timer_table_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .timer_index   (timer_index),
    .timeout_ticks (timeout_ticks),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .entry_index   (entry_index),
    .expired_data  (expired_data),
    .ticks_seen    (ticks_seen),
    .last          (last)
  );

  // shadow copy of the timer table
  logic [1:0]  tbl_status [NUM_TIMERS];
  logic [31:0] tbl_timeout [NUM_TIMERS];
  logic [7:0]  tbl_data [NUM_TIMERS];
  logic [31:0] tick_count;

  timer_cmd_t    cmd_queue [$];
  timer_result_t due_results [$];
  timer_cmd_t    cur_cmd;
  bit            have_cmd;
  pace_t         cur_pace = PACE_RX_SLOW;
  int unsigned   hold_requests;

  // stimulus build state
  pace_t fill_pace = PACE_RX_SLOW;
  bit    fill_hold;
  bit    fill_drain;

  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_expired;
  int unsigned n_alloc_fail;
  int unsigned fail_count;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int tx_idle_pct(pace_t p);
    case (p)
      PACE_RX_SLOW: return 11;
      PACE_TX_SLOW: return 72;
      default:      return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct(pace_t p);
    case (p)
      PACE_RX_SLOW: return 72;
      PACE_TX_SLOW: return 11;
      default:      return 0;
    endcase
  endfunction

  function automatic void add_cmd(logic [2:0] op, logic [3:0] idx, logic [31:0] tmo,
                                  logic [7:0] dat);
    timer_cmd_t c;
    c.op          = op;
    c.index       = idx;
    c.timeout     = tmo;
    c.data        = dat;
    c.pace        = fill_pace;
    c.hold_rx     = fill_hold;
    c.drain_first = fill_drain;
    fill_hold     = 1'b0;
    fill_drain    = 1'b0;
    cmd_queue.push_back(c);
  endfunction

  // shadow table update and expected results for one accepted transaction
  function automatic void predict_timer_results(timer_cmd_t c);
    timer_result_t r;
    timer_result_t burst [$];
    bit claimed;
    bit in_range;
    r        = '0;
    claimed  = 1'b0;
    in_range = int'(c.index) < NUM_TIMERS;
    case (c.op)
      OP_ALLOC: begin
        r.kind = K_FAIL;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (!claimed && tbl_status[i] == ST_FREE) begin
            tbl_status[i] = ST_ALLOC;
            r.kind  = K_ALLOC;
            r.index = 4'(i);
            claimed = 1'b1;
          end
        end
      end
      OP_FREE: begin
        if (in_range) tbl_status[c.index] = ST_FREE;
        r.kind = K_DONE;
      end
      OP_SET_DATA: begin
        if (in_range) tbl_data[c.index] = c.data;
        r.kind = K_DONE;
      end
      OP_SET_TIMEOUT: begin
        if (in_range) begin
          tbl_timeout[c.index] = c.timeout;
          tbl_status[c.index]  = ST_RUN;
        end
        r.kind = K_DONE;
      end
      OP_TICK: begin
        tick_count = tick_count + 32'd1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (tbl_status[i] == ST_RUN) begin
            tbl_timeout[i] = tbl_timeout[i] - 32'd1;
            if (tbl_timeout[i] == 32'd0) begin
              tbl_status[i] = ST_ALLOC;
              if (burst.size() < MAX_RESULTS) begin
                r.kind  = K_EXPIRED;
                r.index = 4'(i);
                r.data  = tbl_data[i];
                r.ticks = tick_count;
                burst.push_back(r);
              end
            end
          end
        end
        r = '0;
        r.kind = K_NOEXP;
      end
      default: r.kind = K_DONE;
    endcase
    r.ticks = tick_count;
    if (burst.size() == 0) burst.push_back(r);
    burst[burst.size() - 1].last = 1'b1;
    foreach (burst[k]) due_results.push_back(burst[k]);
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // driver: offers queued transactions, holds payload until accepted
  always @(posedge clk) begin : drive_proc
    bit fire;
    bit offer;
    if (rst) begin
      in_valid <= 1'b0;
      have_cmd = 1'b0;
    end else begin
      fire  = in_valid && !in_stall;
      offer = in_valid && !fire;
      if (fire) begin
        predict_timer_results(cur_cmd);
        n_accepted++;
        have_cmd = 1'b0;
      end
      // a drain mark waits until every outstanding result has come back
      if (!have_cmd && cmd_queue.size() != 0 &&
          !(cmd_queue[0].drain_first && due_results.size() != 0)) begin
        cur_cmd  = cmd_queue.pop_front();
        have_cmd = 1'b1;
        cur_pace = cur_cmd.pace;
        if (cur_cmd.hold_rx) hold_requests++;
        operation     <= cur_cmd.op;
        timer_index   <= cur_cmd.index;
        timeout_ticks <= cur_cmd.timeout;
        data_byte     <= cur_cmd.data;
      end
      if (have_cmd && !offer)
        offer = $urandom_range(0, 99) >= tx_idle_pct(cur_pace);
      in_valid <= have_cmd && offer;
    end
  end

  // output back-pressure, with an occasional long hold
  always @(posedge clk) begin : sink_proc
    int unsigned holds_served;
    int unsigned hold_left;
    if (rst) begin
      out_stall <= 1'b0;
      holds_served = 0;
      hold_left    = 0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= $urandom_range(0, 99) < rx_idle_pct(cur_pace);
      end
    end
  end

  // monitor: compare each output transaction with the oldest expectation
  always @(posedge clk) begin : check_proc
    timer_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d index %0d", result_kind, entry_index);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("result_kind", 64'(want.kind), 64'(result_kind));
        check_field("entry_index", 64'(want.index), 64'(entry_index));
        check_field("expired_data", 64'(want.data), 64'(expired_data));
        check_field("ticks_seen", 64'(want.ticks), 64'(ticks_seen));
        check_field("last", 64'(want.last), 64'(last));
        n_checked++;
        if (want.kind == K_EXPIRED) n_expired++;
        if (want.kind == K_FAIL) n_alloc_fail++;
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timed out with %0d results outstanding", due_results.size());
    $display("status: fail");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int unsigned rand_base;
    logic [3:0]  r;
    pace_t       next_pace;

    for (int i = 0; i < NUM_TIMERS; i++) begin
      tbl_status[i]  = ST_FREE;
      tbl_timeout[i] = '0;
      tbl_data[i]    = '0;
    end
    tick_count = '0;

    // directed: empty tick, reserved codes, expiries, zero and max timeouts
    add_cmd(OP_TICK, 4'h0, 32'h0, 8'h00);
    add_cmd(OP_RSVD_5, 4'hF, 32'hFFFF_FFFF, 8'hFF);
    add_cmd(OP_RSVD_6, 4'h0, 32'h0, 8'h00);
    add_cmd(OP_RSVD_7, 4'h9, 32'hA5A5_5A5A, 8'h3C);
    add_cmd(OP_ALLOC, 4'h0, 32'h0, 8'h00);
    add_cmd(OP_SET_DATA, 4'h0, 32'h0, 8'hFF);
    add_cmd(OP_SET_TIMEOUT, 4'h0, 32'd1, 8'h00);
    add_cmd(OP_ALLOC, 4'h0, 32'h0, 8'h00);
    add_cmd(OP_SET_DATA, 4'h1, 32'h0, 8'hA5);
    add_cmd(OP_SET_TIMEOUT, 4'h1, 32'd2, 8'h00);
    add_cmd(OP_SET_DATA, 4'hF, 32'h0, 8'h5A);
    add_cmd(OP_SET_TIMEOUT, 4'hF, 32'd1, 8'h00);
    add_cmd(OP_TICK, 4'h0, 32'h0, 8'h00);
    add_cmd(OP_TICK, 4'h0, 32'h0, 8'h00);
    add_cmd(OP_SET_TIMEOUT, 4'h2, 32'h0, 8'h00);
    add_cmd(OP_SET_TIMEOUT, 4'h3, 32'hFFFF_FFFF, 8'h00);
    add_cmd(OP_TICK, 4'h0, 32'h0, 8'h00);
    add_cmd(OP_FREE, 4'h2, 32'h0, 8'h00);
    add_cmd(OP_FREE, 4'h3, 32'h0, 8'h00);
    add_cmd(OP_FREE, 4'h0, 32'h0, 8'h00);
    add_cmd(OP_FREE, 4'h4, 32'h0, 8'h00);
    add_cmd(OP_SET_TIMEOUT, 4'h0, 32'd1, 8'h00);
    add_cmd(OP_SET_DATA, 4'h0, 32'h0, 8'h00);
    add_cmd(OP_TICK, 4'h0, 32'h0, 8'h00);

    // random: mostly free/alloc/arm sequences plus ticks and noise
    rand_base = cmd_queue.size();
    while (cmd_queue.size() - rand_base < RANDOM_ITEMS) begin
      if (cmd_queue.size() - rand_base >= 2 * RANDOM_ITEMS / 3)
        next_pace = PACE_FULL;
      else if (cmd_queue.size() - rand_base >= RANDOM_ITEMS / 3)
        next_pace = PACE_TX_SLOW;
      else
        next_pace = PACE_RX_SLOW;
      if (next_pace != fill_pace) begin
        fill_pace  = next_pace;
        fill_drain = 1'b1;
      end
      r = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          add_cmd(OP_FREE, r, $urandom(), 8'($urandom_range(0, 255)));
          add_cmd(OP_ALLOC, 4'($urandom_range(0, 15)), $urandom(), 8'h00);
          add_cmd(OP_SET_DATA, r, $urandom(), 8'($urandom_range(0, 255)));
          add_cmd(OP_SET_TIMEOUT, r, 32'($urandom_range(1, 5)), 8'h00);
        end
        4, 5: begin
          repeat ($urandom_range(1, 3)) add_cmd(OP_TICK, r, $urandom(), 8'h00);
        end
        6: add_cmd(OP_FREE, r, 32'h0, 8'h00);
        7: add_cmd(3'($urandom_range(0, 7)), r, $urandom(), 8'($urandom_range(0, 255)));
        8: add_cmd(OP_SET_TIMEOUT, r, $urandom(), 8'($urandom_range(0, 255)));
        default: begin
          add_cmd(OP_SET_TIMEOUT, r, 32'($urandom_range(1, 3)), 8'h00);
          add_cmd(OP_TICK, 4'h0, 32'h0, 8'h00);
        end
      endcase
    end

    // full table: seventeen allocations cannot all succeed
    fill_pace  = PACE_FULL;
    fill_drain = 1'b1;
    repeat (NUM_TIMERS + 1) add_cmd(OP_ALLOC, 4'h0, 32'h0, 8'h00);

    // every entry expires on one tick while the output is held off
    for (int i = 0; i < NUM_TIMERS; i++)
      add_cmd(OP_SET_TIMEOUT, 4'(i), 32'd1, 8'h00);
    fill_hold = 1'b1;
    add_cmd(OP_TICK, 4'h0, 32'h0, 8'h00);
    repeat (3) add_cmd(OP_TICK, 4'h0, 32'h0, 8'h00);
    add_cmd(OP_ALLOC, 4'h0, 32'h0, 8'h00);
    add_cmd(OP_SET_DATA, 4'h7, 32'h0, 8'h81);
    fill_drain = 1'b1;
    add_cmd(OP_FREE, 4'h7, 32'h0, 8'h00);
    add_cmd(OP_ALLOC, 4'h0, 32'h0, 8'h00);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || have_cmd || due_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d transactions in and %0d results out", n_accepted, n_checked);
    $display("including %0d expiries and %0d failed allocations", n_expired, n_alloc_fail);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### files.f
design/mtt_pkg.sv
design/mtt_cell.sv
design/mtt_proc.sv
design/multi_timer_table_core.sv
tb/sv/multi_timer_table_core_tb.sv
